// ===== rtl/assert_macros.svh =====
// assertion macros shared by the allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define CBBA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define CBBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cbba_pkg.sv =====
// package with types and constants for the contiguous block allocator
`default_nettype none
package cbba_pkg;

  // default map size in blocks
  localparam int NUM_BLOCKS_DEF = 128;

  // fixed field widths
  localparam int KIND_W   = 2;
  localparam int FIRST_W  = 7;
  localparam int LEN_W    = 8;
  localparam int START_W  = 7;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_FIND  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [FIRST_W-1:0] first_block;
    logic [LEN_W-1:0]   run_length;
  } item_t;

  typedef struct packed {
    logic               found;
    logic [START_W-1:0] start_block;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_t;

  // control from sequencer to scan unit
  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctl_t;

  // status from scan unit to sequencer
  typedef struct packed {
    logic               last;
    logic               found;
    logic [START_W-1:0] start_block;
  } scan_status_t;

endpackage
`default_nettype wire

// ===== rtl/cbba_ring.sv =====
// circular shift register holding the allocation map, one block per bit
`default_nettype none
module cbba_ring import cbba_pkg::*; #(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic shift,
  input  wire logic bit_in,
  output logic      head
);

  logic [NUM_BLOCKS-1:0] ring;

  // rotate toward bit 0, written-back bit enters at the top
  always_ff @(posedge clk) begin
    if (rst) begin
      ring <= '0;
    end else if (shift) begin
      ring <= {bit_in, ring[NUM_BLOCKS-1:1]};
    end
  end

  assign head = ring[0];

endmodule
`default_nettype wire

// ===== rtl/cbba_scan.sv =====
// per-block evaluation: range marking and first-fit run tracking
`default_nettype none
`include "assert_macros.svh"
module cbba_scan import cbba_pkg::*; #(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire scan_ctl_t    ctl,
  input  wire item_t        item,
  input  wire logic         head,
  output logic              bit_out,
  output scan_status_t      status
);

  localparam int CW = $clog2(NUM_BLOCKS);
  localparam int EW = (CW > 9) ? CW + 1 : 10;

  logic [CW-1:0]      cnt;
  logic [LEN_W-1:0]   run;
  logic               found;
  logic [START_W-1:0] start_block;

  logic               last;
  logic [EW-1:0]      cnt_x;
  logic [EW-1:0]      first_x;
  logic [EW-1:0]      end_x;
  logic [EW-1:0]      len_x;
  logic [EW-1:0]      start_x;
  logic               in_range;
  logic               is_mark;
  logic               len_ok;
  logic               blk_free;
  logic [LEN_W-1:0]   run_inc;
  logic               hit;

  // block index and range compare
  always_comb begin
    last     = (cnt == CW'(NUM_BLOCKS - 1));
    cnt_x    = EW'(cnt);
    first_x  = EW'(item.first_block);
    len_x    = EW'(item.run_length);
    end_x    = first_x + len_x;
    in_range = (cnt_x >= first_x) && (cnt_x < end_x);
    is_mark  = (item.kind == KIND_ALLOC) || (item.kind == KIND_FREE);
    bit_out  = (is_mark && in_range) ? (item.kind == KIND_ALLOC) : head;
  end

  // run tracking for find, block 0 never starts a run
  always_comb begin
    len_ok   = (item.run_length != '0) && (len_x <= EW'(NUM_BLOCKS - 1));
    blk_free = !head && (cnt != '0);
    run_inc  = run + LEN_W'(1);
    hit      = (item.kind == KIND_FIND) && len_ok && !found && blk_free &&
               (run_inc == item.run_length);
    start_x  = cnt_x + EW'(1) - len_x;
  end

  // counter, run length and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      run   <= '0;
      found <= 1'b0;
    end else if (ctl.clear) begin
      cnt   <= '0;
      run   <= '0;
      found <= 1'b0;
    end else if (ctl.step) begin
      cnt <= last ? '0 : cnt + CW'(1);
      run <= blk_free ? run_inc : '0;
      if (hit) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      start_block <= '0;
    end else if (ctl.step && hit) begin
      start_block <= start_x[START_W-1:0];
    end
  end

  assign status.last        = last;
  assign status.found       = found;
  assign status.start_block = start_block;

  // checks
  `CBBA_ASSERT_NEXT(a_found_sticky, found && !ctl.clear, found,
    "found flag dropped during a scan")
  `CBBA_ASSERT_NEXT(a_cnt_wrap, ctl.step && last && !ctl.clear, cnt == '0,
    "block counter did not wrap after the last block")
  `CBBA_ASSERT_IMPL(a_hit_nonzero, ctl.step && hit, start_x != '0,
    "find hit reports block zero as start")

endmodule
`default_nettype wire

// ===== rtl/contiguous_block_bitmap_allocator_top.sv =====
// A result is loaded into the output register after the transaction's full map rotation.
// A new transaction is accepted only after the previous result is loaded, which waits while the output stalls.
// Every operation rotates the whole map ring once, one block per cycle.
// The output register holds a result while the next rotation is set up.
// Reset (synchronous) clears the whole map to free and empties the output.
`default_nettype none
`include "assert_macros.svh"
module contiguous_block_bitmap_allocator_top import cbba_pkg::*; #(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire item_t   in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_data
);

  state_t       st;
  state_t       st_next;
  item_t        item;
  scan_ctl_t    ctl;
  scan_status_t status;
  logic         head;
  logic         bit_back;
  logic         in_fire;
  logic         out_load;

  // map storage
  cbba_ring #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_ring (
    .clk    (clk),
    .rst    (rst),
    .shift  (ctl.step),
    .bit_in (bit_back),
    .head   (head)
  );

  // per-block evaluation
  cbba_scan #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .item    (item),
    .head    (head),
    .bit_out (bit_back),
    .status  (status)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  // next state and control
  always_comb begin
    st_next   = st;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    ctl.clear = 1'b0;
    ctl.step  = 1'b0;
    case (st)
      ST_IDLE: begin
        in_ready  = 1'b1;
        ctl.clear = in_valid;
        if (in_valid) begin
          st_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctl.step = 1'b1;
        if (status.last) begin
          st_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        out_load = !out_valid || out_ready;
        if (out_load) begin
          st_next = ST_IDLE;
        end
      end
      default: begin
        st_next = ST_IDLE;
      end
    endcase
  end

  assign in_fire = in_valid && in_ready;

  // captured transaction
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item <= in_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.found       <= status.found;
      out_data.start_block <= status.start_block;
    end
  end

  // checks
  `CBBA_ASSERT_NEXT(a_fire_scan, in_fire, st == ST_SCAN,
    "accepted transaction did not start a scan")
  `CBBA_ASSERT_NEXT(a_load_valid, out_load, out_valid,
    "loaded result not presented")
  `CBBA_ASSERT_IMPL(a_no_accept_busy, st != ST_IDLE, !in_fire,
    "transaction accepted while busy")

endmodule
`default_nettype wire

// ===== test/cbba_allocation_checker.sv =====
// checker that mirrors the block allocation map and compares every allocator result
module cbba_allocation_checker import cbba_pkg::*; #(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_ready,
  input  item_t   in_data,
  input  logic    out_valid,
  input  logic    out_ready,
  input  result_t out_data,
  output int      mismatch_count,
  output int      pending_results
);

  // mirror of the allocation map, 1 = allocated
  logic [NUM_BLOCKS-1:0] block_map;
  // predicted results in transaction order
  result_t expected_grants[$];
  int mismatch_total = 0;

  task automatic report_mismatch(input string msg);
    mismatch_total++;
    $display("[%0t] allocator mismatch: %s", $time, msg);
  endtask

  // set or clear a range, dropping blocks past the end of the map
  function automatic void mark_blocks(input int first, input int len, input logic value);
    for (int b = first; b < first + len && b < NUM_BLOCKS; b++) begin
      block_map[b] = value;
    end
  endfunction

  // apply one transaction to the mirror and return the result it should give
  function automatic result_t predict_grant(input item_t it);
    result_t grant;
    int run;
    grant = '0;
    run = 0;
    case (it.kind)
      KIND_FIND: begin
        // first fit over blocks 1 and up; block 0 never starts a run
        if (it.run_length != 0 && it.run_length <= NUM_BLOCKS - 1) begin
          for (int b = 1; b < NUM_BLOCKS; b++) begin
            if (block_map[b]) begin
              run = 0;
            end else begin
              run++;
              if (run == it.run_length && !grant.found) begin
                grant.found       = 1'b1;
                grant.start_block = START_W'(b + 1 - run);
              end
            end
          end
        end
      end
      KIND_ALLOC: mark_blocks(int'(it.first_block), int'(it.run_length), 1'b1);
      KIND_FREE:  mark_blocks(int'(it.first_block), int'(it.run_length), 1'b0);
      default: ;
    endcase
    return grant;
  endfunction

  // watch both channels on the clock edge
  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      block_map = '0;
      expected_grants.delete();
    end else begin
      if (in_valid && in_ready) begin
        expected_grants.push_back(predict_grant(in_data));
      end
      if (out_valid && out_ready) begin
        if (expected_grants.size() == 0) begin
          report_mismatch($sformatf("result found=%0d start=%0d with no transaction waiting",
                                    out_data.found, out_data.start_block));
        end else begin
          want = expected_grants.pop_front();
          if (out_data.found !== want.found) begin
            report_mismatch($sformatf("found got %0d want %0d", out_data.found, want.found));
          end
          if (out_data.start_block !== want.start_block) begin
            report_mismatch($sformatf("start_block got %0d want %0d",
                                      out_data.start_block, want.start_block));
          end
        end
      end
    end
    mismatch_count  <= mismatch_total;
    pending_results <= expected_grants.size();
  end

endmodule

// ===== test/tb_contiguous_block_bitmap_allocator_top.sv =====
// testbench top: drives allocator transactions, stalls the output and gives the verdict
module tb_contiguous_block_bitmap_allocator_top;
  import cbba_pkg::*;

  // kind code with no operation behind it
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 700;
  localparam int MAX_GAP      = 160;
  localparam int MAX_STALL    = 40;

  logic    clk;
  logic    rst;
  logic    in_valid;
  logic    in_ready;
  item_t   in_data;
  logic    out_valid;
  logic    out_ready;
  result_t out_data;
  int      mismatch_count;
  int      pending_results;
  int      burst_left = 0;
  int      ready_hold = 0;

  contiguous_block_bitmap_allocator_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  cbba_allocation_checker allocation_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: long ready stretches broken by stalls of random length
  always @(posedge clk) begin
    if (ready_hold == 0) begin
      if ($urandom_range(0, 2) != 0) begin
        out_ready  <= 1'b1;
        ready_hold <= $urandom_range(1, 400);
      end else begin
        out_ready  <= 1'b0;
        ready_hold <= $urandom_range(1, MAX_STALL);
      end
    end else begin
      ready_hold <= ready_hold - 1;
    end
  end

  function automatic item_t make_item(input logic [KIND_W-1:0] kind, input int first,
                                      input int len);
    item_t it;
    it.kind        = kind;
    it.first_block = FIRST_W'(first);
    it.run_length  = LEN_W'(len);
    return it;
  endfunction

  // mostly short runs, some up to the full map, a few past any legal length
  function automatic item_t random_item();
    item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)      it.kind = KIND_FIND;
    else if (pick < 70) it.kind = KIND_ALLOC;
    else if (pick < 96) it.kind = KIND_FREE;
    else                it.kind = KIND_UNUSED;
    pick = $urandom_range(0, 99);
    if (pick < 85)      it.run_length = LEN_W'($urandom_range(1, 16));
    else if (pick < 97) it.run_length = LEN_W'($urandom_range(0, 128));
    else                it.run_length = LEN_W'($urandom_range(0, 255));
    it.first_block = FIRST_W'($urandom_range(0, 127));
    return it;
  endfunction

  // hold valid until the transaction is taken
  task automatic send_item(input item_t it);
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // bursts of random length with random gaps between them
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 7);
      gap = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 10) : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop sending until every predicted result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  initial begin
    item_t directed[$];
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // edge cases on an empty map, then on a full one
    directed = '{
      make_item(KIND_FIND, 0, 0),       // zero length find
      make_item(KIND_FIND, 127, 1),
      make_item(KIND_FIND, 0, 127),     // whole usable map
      make_item(KIND_FIND, 0, 128),     // longer than usable blocks
      make_item(KIND_FIND, 0, 255),
      make_item(KIND_UNUSED, 127, 255), // no operation
      make_item(KIND_ALLOC, 0, 1),      // reserved block written
      make_item(KIND_FIND, 0, 127),
      make_item(KIND_ALLOC, 120, 128),  // clipped at the end of the map
      make_item(KIND_FIND, 0, 119),
      make_item(KIND_FIND, 0, 120),
      make_item(KIND_ALLOC, 127, 0),    // zero length mark
      make_item(KIND_FREE, 0, 128),
      make_item(KIND_ALLOC, 1, 127),
      make_item(KIND_FIND, 0, 1),       // no free run
      make_item(KIND_FREE, 64, 1),
      make_item(KIND_FIND, 0, 1),
      make_item(KIND_FIND, 0, 2),
      make_item(KIND_FREE, 127, 1),
      make_item(KIND_FIND, 0, 1),
      make_item(KIND_FREE, 42, 85),
      make_item(KIND_ALLOC, 85, 42),
      make_item(KIND_FIND, 0, 40),
      make_item(KIND_FREE, 0, 255)
    };
    foreach (directed[i]) begin
      send_item(directed[i]);
      pace_sender();
    end
    drain_results();

    // random traffic, with a full drain now and then
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      send_item(random_item());
      if (n % 150 == 149) drain_results();
      else pace_sender();
    end
    drain_results();
    repeat (NUM_BLOCKS_DEF + 20) @(posedge clk);

    if (mismatch_count == 0 && pending_results == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // stop with a failure verdict if the run hangs
  initial begin
    #8000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/cbba_pkg.sv
rtl/cbba_ring.sv
rtl/cbba_scan.sv
rtl/contiguous_block_bitmap_allocator_top.sv
test/cbba_allocation_checker.sv
test/tb_contiguous_block_bitmap_allocator_top.sv
